// File: rtl/assert_macros.svh
// Assertion macros shared by the tracker's RTL files.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define PSTRK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pstrk assertion failed");

// Clocked check that also holds during reset.
`define PSTRK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pstrk assertion failed");

`endif

// File: rtl/pstrk_pkg.sv
// Types and constants of the per-source chunk sequence tracker.
// No dependencies; used by the controller, datapath and top level.
package pstrk_pkg;

  localparam int unsigned IP_W     = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned CHUNK_W  = 32;
  localparam int unsigned OUT_SLOT_W = 3;

  localparam logic signed [CHUNK_W-1:0] CNT_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [2:0] {
    OC_NO_SLOT       = 3'd0,
    OC_AHEAD         = 3'd1,
    OC_ACCEPTED      = 3'd2,
    OC_ACCEPTED_LAST = 3'd3,
    OC_DUPLICATE     = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH,
    ST_DECIDE
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the input item
    logic search;   // latch lookup result
    logic commit;   // update table, load output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_room; // output register can take a result this cycle
  } dp_status_t;

endpackage

// File: rtl/pstrk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pstrk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pstrk_ctrl.sv
// Controller of the chunk tracker: sequences capture, search, fetch, decide.
// Depends on pstrk_pkg.
module pstrk_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pstrk_pkg::dp_status_t  status,
  output pstrk_pkg::ctrl_cmd_t   cmd
);

  import pstrk_pkg::*;

  ctrl_state_t state, state_next;
  logic        take;

  // An item can be taken when idle, or in the cycle the current one commits.
  assign take = in_valid &&
                ((state == ST_IDLE) || ((state == ST_DECIDE) && status.out_room));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) state_next = ST_SEARCH;
      end
      ST_SEARCH: state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (status.out_room) state_next = take ? ST_SEARCH : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_SEARCH: cmd.search = 1'b1;
      ST_FETCH: begin
      end
      ST_DECIDE: begin
        in_stall    = !status.out_room;
        cmd.commit  = status.out_room;
        cmd.capture = take;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/pstrk_dp.sv
// Datapath of the chunk tracker: sender table, count RAM, compare, output register.
// Depends on pstrk_pkg and pstrk_ram.
module pstrk_dp #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  pstrk_pkg::ctrl_cmd_t                    cmd,
  output pstrk_pkg::dp_status_t                   status,
  input  logic [pstrk_pkg::IP_W-1:0]              src_ip,
  input  logic [pstrk_pkg::PORT_W-1:0]            src_port,
  input  logic signed [pstrk_pkg::CHUNK_W-1:0]    chunk_number,
  input  logic                                    last_chunk,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output pstrk_pkg::outcome_t                     outcome,
  output logic                                    send_ack,
  output logic [pstrk_pkg::OUT_SLOT_W-1:0]        slot_used,
  output logic signed [pstrk_pkg::CHUNK_W-1:0]    expected_next
);

  import pstrk_pkg::*;

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Captured item
  logic [IP_W-1:0]           ip_q;
  logic [PORT_W-1:0]         port_q;
  logic signed [CHUNK_W-1:0] chunk_q;
  logic                      last_q;

  // Sender table (flops, compared in parallel)
  logic              busy     [NUM_SLOTS];
  logic [IP_W-1:0]   slot_ip  [NUM_SLOTS];
  logic [PORT_W-1:0] slot_port[NUM_SLOTS];

  // Lookup
  logic              hit, free;
  logic [SLOT_W-1:0] match_idx, free_idx;
  logic              hit_q, have_q;
  logic [SLOT_W-1:0] pos_q;

  // Decide
  logic signed [CHUNK_W-1:0] cnt_rd, last_cnt;
  logic signed [CHUNK_W:0]   want, chunk_ext;
  logic                      ahead, equal;
  logic signed [CHUNK_W-1:0] want_sat;
  logic signed [CHUNK_W-1:0] acc_next;
  logic                      ram_we;
  logic signed [CHUNK_W-1:0] ram_wdata;
  outcome_t                  oc;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ip_q    <= src_ip;
      port_q  <= src_port;
      chunk_q <= chunk_number;
      last_q  <= last_chunk;
    end
  end

  // Lowest matching busy slot; highest free slot.
  always_comb begin
    hit       = 1'b0;
    match_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (busy[i] && (slot_ip[i] == ip_q) && (slot_port[i] == port_q)) begin
        hit       = 1'b1;
        match_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    free     = 1'b0;
    free_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!busy[i]) begin
        free     = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_q  <= hit;
      have_q <= hit || free;
      pos_q  <= hit ? match_idx : free_idx;
    end
  end

  // Count store; read address is held from search through decide.
  pstrk_ram #(
    .WIDTH (CHUNK_W),
    .DEPTH (NUM_SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_q),
    .wdata (ram_wdata),
    .raddr (pos_q),
    .rdata (cnt_rd)
  );

  // Fresh slot starts at 0.
  assign last_cnt  = hit_q ? cnt_rd : '0;
  assign want      = {last_cnt[CHUNK_W-1], last_cnt} + (CHUNK_W+1)'(1);
  assign chunk_ext = {chunk_q[CHUNK_W-1], chunk_q};
  assign ahead     = chunk_ext > want;
  assign equal     = chunk_ext == want;
  // Not accepted: count unchanged, next expected is want (saturating).
  assign want_sat  = (want[CHUNK_W:CHUNK_W-1] == 2'b01) ? CNT_MAX : want[CHUNK_W-1:0];
  // Accepted: count becomes the chunk, next expected is chunk + 1 (saturating).
  assign acc_next  = (chunk_q == CNT_MAX) ? CNT_MAX : chunk_q + CHUNK_W'(1);

  assign ram_we    = cmd.commit && have_q && (!hit_q || equal);
  assign ram_wdata = equal ? chunk_q : last_cnt;

  always_comb begin
    priority if (!have_q) oc = OC_NO_SLOT;
    else if (ahead)       oc = OC_AHEAD;
    else if (equal)       oc = last_q ? OC_ACCEPTED_LAST : OC_ACCEPTED;
    else                  oc = OC_DUPLICATE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        busy[i] <= 1'b0;
      end
    end else if (cmd.commit && have_q) begin
      busy[pos_q] <= !(equal && last_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && have_q) begin
      slot_ip[pos_q]   <= ip_q;
      slot_port[pos_q] <= port_q;
    end
  end

  // Output register
  assign status.out_room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      outcome       <= oc;
      send_ack      <= have_q && !ahead;
      slot_used     <= have_q ? OUT_SLOT_W'(pos_q) : '0;
      expected_next <= have_q ? (equal ? acc_next : want_sat) : '0;
    end
  end

endmodule

// File: rtl/per_source_chunk_sequence_tracker.sv
// Per-source chunk sequence tracker. Each item is one datagram header (sender
// address, port, signed chunk number, last flag); each item yields exactly one
// result: outcome, ack flag, table slot and the chunk number now expected.
// Each item passes through capture/search, count fetch from the count RAM
// and decide/commit; the next item is taken in the commit cycle.
// The table lookup compares all NUM_SLOTS entries in parallel, then the slot's
// count is read from a registered-read RAM, which adds the count fetch step.
// The output register holds one finished result; while it is stalled the
// block takes at most one more item, holds it in decide and stalls its input.
// No clearing pass after reset: busy flags reset at once, counts and addresses
// are written when a slot is taken. Depends on pstrk_pkg, pstrk_ctrl, pstrk_dp,
// pstrk_ram and assert_macros.svh.
`include "assert_macros.svh"

module per_source_chunk_sequence_tracker #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input item channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [pstrk_pkg::IP_W-1:0]            src_ip,
  input  logic [pstrk_pkg::PORT_W-1:0]          src_port,
  input  logic signed [pstrk_pkg::CHUNK_W-1:0]  chunk_number,
  input  logic                                  last_chunk,
  // result item channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output pstrk_pkg::outcome_t                   outcome,
  output logic                                  send_ack,
  output logic [pstrk_pkg::OUT_SLOT_W-1:0]      slot_used,
  output logic signed [pstrk_pkg::CHUNK_W-1:0]  expected_next
);

  import pstrk_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pstrk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pstrk_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .src_ip        (src_ip),
    .src_port      (src_port),
    .chunk_number  (chunk_number),
    .last_chunk    (last_chunk),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .outcome       (outcome),
    .send_ack      (send_ack),
    .slot_used     (slot_used),
    .expected_next (expected_next)
  );

  // An accepted item keeps the input stalled for the following search cycle.
  `PSTRK_ASSERT(a_accept_then_busy, clk, rst, (in_valid && !in_stall) |=> in_stall)

  // Ack goes with accepted, accepted-last and duplicate outcomes only.
  `PSTRK_ASSERT(a_ack_matches_outcome, clk, rst, out_valid |-> (send_ack == ((outcome == OC_ACCEPTED) || (outcome == OC_ACCEPTED_LAST) || (outcome == OC_DUPLICATE))))

  // A dropped-for-no-slot result reports slot 0 and count 0.
  `PSTRK_ASSERT(a_no_slot_zero, clk, rst, (out_valid && (outcome == OC_NO_SLOT)) |-> ((slot_used == '0) && (expected_next == '0)))

  // A tracked slot always expects a positive chunk number.
  `PSTRK_ASSERT(a_expected_positive, clk, rst, (out_valid && (outcome != OC_NO_SLOT)) |-> (expected_next > 0))

endmodule
